FILE: hdl/sha1_pkg.sv
package sha1_pkg;

	// Block geometry
	localparam int BLOCK_BYTES = 64;
	localparam int SCHED_WORDS = 16;
	localparam int NUM_ROUNDS  = 80;
	localparam int NUM_WORDS   = 5;

	// Input kinds
	localparam logic FUNC_ABSORB = 1'b0;
	localparam logic FUNC_FINISH = 1'b1;

	// Padding constants
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	// Round constants
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	// Initial chaining values
	localparam logic [31:0] H_INIT [NUM_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	// Working variables of the compression
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} work_t;

	// Control of the block buffer / schedule line
	typedef struct packed {
		logic load;   // shift one byte in
		logic shift;  // advance the schedule by one word
	} sched_ctrl_t;

endpackage

FILE: hdl/sha1_message_digest_unit.sv
// Absorb item: a byte that completes a 64-byte block starts a compression that keeps the
// unit busy (80 rounds of the shared round unit plus one chaining add).
// Finish item: padding bytes one per cycle, one or two block compressions, then five
// digest items one per cycle, stalled by m_axis_tready. Input is not taken while busy.
// arst_n (asynchronous, active low) restores the initial chaining values and clears
// the byte count, fill index and sequencer; the block buffer is not reset.
module sha1_message_digest_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] digest_word
	output logic [2:0]  m_axis_tuser,   // [2:0] word_index
	output logic        m_axis_tlast    // last_word
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAD   = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_ADD   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	localparam logic [6:0] LAST_RND  = 7'(sha1_pkg::NUM_ROUNDS - 1);
	localparam logic [2:0] LAST_WORD = 3'(sha1_pkg::NUM_WORDS - 1);

	logic [2:0]            state_q;
	logic [5:0]            fill_q;
	logic [60:0]           count_q;
	logic [63:0]           len_q;
	logic                  len_ph_q;
	logic                  fin_q;
	logic [6:0]            rnd_q;
	logic [2:0]            idx_q;
	logic [31:0]           h_q [sha1_pkg::NUM_WORDS];
	sha1_pkg::work_t       work_q;
	sha1_pkg::work_t       work_nxt;
	sha1_pkg::sched_ctrl_t sctl;
	logic [31:0]           w;
	logic                  in_acc;
	logic                  push_en;
	logic                  wrap;
	logic                  len_byte;
	logic [7:0]            push_byte;
	logic                  out_load;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign len_byte      = len_ph_q | (fill_q == sha1_pkg::LEN_POS);
	assign push_en       = in_acc | (state_q == ST_PAD);
	assign wrap          = push_en & (&fill_q);
	assign out_load      = (state_q == ST_OUT) & (~m_axis_tvalid | m_axis_tready);

	// Pick the byte to push: message, pad marker, zero fill or length
	always_comb begin
		if (state_q == ST_IDLE) begin
			push_byte = (s_axis_tuser == sha1_pkg::FUNC_FINISH) ? sha1_pkg::PAD_BYTE
			                                                     : s_axis_tdata;
		end else begin
			push_byte = len_byte ? len_q[63:56] : 8'h00;
		end
	end

	assign sctl.load  = push_en;
	assign sctl.shift = (state_q == ST_ROUND);

	sha1_sched u_sched (
		.clk     (clk),
		.ctrl    (sctl),
		.byte_in (push_byte),
		.w       (w)
	);

	sha1_round u_round (
		.cur (work_q),
		.w   (w),
		.rnd (rnd_q),
		.nxt (work_nxt)
	);

	// Working variables: load from chain on block start, advance per round
	always_ff @(posedge clk) begin
		if (wrap) begin
			work_q <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
		end else if (state_q == ST_ROUND) begin
			work_q <= work_nxt;
		end
	end

	// Sequencer, counters and chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			count_q  <= '0;
			len_ph_q <= 1'b0;
			fin_q    <= 1'b0;
			rnd_q    <= '0;
			idx_q    <= '0;
			for (int i = 0; i < sha1_pkg::NUM_WORDS; i++) begin
				h_q[i] <= sha1_pkg::H_INIT[i];
			end
		end else begin
			if (push_en) begin
				fill_q <= fill_q + 6'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_axis_tuser == sha1_pkg::FUNC_ABSORB) begin
							count_q <= count_q + 61'd1;
						end else begin
							fin_q    <= 1'b1;
							len_ph_q <= 1'b0;
						end
						if (wrap) begin
							rnd_q   <= '0;
							state_q <= ST_ROUND;
						end else if (s_axis_tuser == sha1_pkg::FUNC_FINISH) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (len_byte) begin
						len_ph_q <= 1'b1;
					end
					if (wrap) begin
						rnd_q   <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == LAST_RND) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					h_q[0] <= h_q[0] + work_q.a;
					h_q[1] <= h_q[1] + work_q.b;
					h_q[2] <= h_q[2] + work_q.c;
					h_q[3] <= h_q[3] + work_q.d;
					h_q[4] <= h_q[4] + work_q.e;
					priority if (fin_q && len_ph_q) begin
						idx_q   <= '0;
						state_q <= ST_OUT;
					end else if (fin_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						if (idx_q == LAST_WORD) begin
							idx_q    <= '0;
							count_q  <= '0;
							fin_q    <= 1'b0;
							len_ph_q <= 1'b0;
							for (int i = 0; i < sha1_pkg::NUM_WORDS; i++) begin
								h_q[i] <= sha1_pkg::H_INIT[i];
							end
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Length field: capture bit count on finish, shift out one byte per length push
	always_ff @(posedge clk) begin
		if (in_acc && s_axis_tuser == sha1_pkg::FUNC_FINISH) begin
			len_q <= {count_q, 3'b000};
		end else if (state_q == ST_PAD && len_byte) begin
			len_q <= {len_q[55:0], 8'h00};
		end
	end

	// Output register: hold a word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata <= h_q[idx_q];
			m_axis_tuser <= idx_q;
			m_axis_tlast <= (idx_q == LAST_WORD);
		end
	end

endmodule

FILE: hdl/sha1_round.sv
module sha1_round (
	input  sha1_pkg::work_t cur,
	input  logic [31:0]     w,
	input  logic [6:0]      rnd,
	output sha1_pkg::work_t nxt
);

	logic [31:0] f;
	logic [31:0] k;

	// Select round function and constant by round group
	always_comb begin
		priority if (rnd < 7'd20) begin
			f = (cur.b & cur.c) | (~cur.b & cur.d);
			k = sha1_pkg::K0;
		end else if (rnd < 7'd40) begin
			f = cur.b ^ cur.c ^ cur.d;
			k = sha1_pkg::K1;
		end else if (rnd < 7'd60) begin
			f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
			k = sha1_pkg::K2;
		end else begin
			f = cur.b ^ cur.c ^ cur.d;
			k = sha1_pkg::K3;
		end
	end

	// One round: new a, rotate the rest down
	always_comb begin
		nxt.a = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;
		nxt.b = cur.a;
		nxt.c = {cur.b[1:0], cur.b[31:2]};
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

endmodule

FILE: hdl/sha1_sched.sv
module sha1_sched (
	input  logic                  clk,
	input  sha1_pkg::sched_ctrl_t ctrl,
	input  logic [7:0]            byte_in,
	output logic [31:0]           w
);

	localparam int BUF_W = sha1_pkg::BLOCK_BYTES * 8;

	// Block buffer, byte 0 ends up in the top bits; word 0 is the current schedule word
	logic [BUF_W-1:0] buf_q;
	logic [31:0]      w2;
	logic [31:0]      w8;
	logic [31:0]      w13;
	logic [31:0]      mix;

	assign w   = buf_q[BUF_W-1 -: 32];
	assign w2  = buf_q[BUF_W-1-2*32 -: 32];
	assign w8  = buf_q[BUF_W-1-8*32 -: 32];
	assign w13 = buf_q[BUF_W-1-13*32 -: 32];
	assign mix = w13 ^ w8 ^ w2 ^ w;

	// Load bytes, or expand the schedule one word per round
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			buf_q <= {buf_q[BUF_W-9:0], byte_in};
		end else if (ctrl.shift) begin
			buf_q <= {buf_q[BUF_W-33:0], mix[30:0], mix[31]};
		end
	end

endmodule

FILE: tb/tb.sv
module tb;

	localparam int TARGET_ITEMS = 470;
	localparam int HOLD_CYCLES  = 600;
	localparam int HOLD_START   = 150;
	localparam int DRAIN_CYCLES = 300;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic       func;
		logic [7:0] data;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
	logic        s_axis_tuser = 1'b0; // [0] func
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // [31:0] digest_word
	logic [2:0]  m_axis_tuser;        // [2:0] word_index
	logic        m_axis_tlast;

	// Stimulus and expectation stores
	msg_item_t    item_q [$];
	digest_word_t digest_q [$];
	int           planned_items = 0;
	int           items_taken = 0;
	int           error_count = 0;
	int           cycle_count = 0;
	int           hold_left = 0;
	bit           hold_done = 1'b0;
	int           send_idle_pct;
	int           recv_idle_pct;

	// Shadow hash state
	logic [31:0] chain_h [sha1_pkg::NUM_WORDS];
	logic [60:0] msg_bytes;
	logic [7:0]  blk_buf [sha1_pkg::BLOCK_BYTES];
	logic [5:0]  blk_fill;

	sha1_message_digest_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run 80 rounds over the buffered block and fold into the chain
	function automatic void compress_block();
		logic [31:0] w [sha1_pkg::NUM_ROUNDS];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int r = 0; r < sha1_pkg::SCHED_WORDS; r++)
			w[r] = {blk_buf[4*r], blk_buf[4*r+1], blk_buf[4*r+2], blk_buf[4*r+3]};
		for (int r = sha1_pkg::SCHED_WORDS; r < sha1_pkg::NUM_ROUNDS; r++) begin
			t = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
			w[r] = {t[30:0], t[31]};
		end
		a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
		for (int r = 0; r < sha1_pkg::NUM_ROUNDS; r++) begin
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = sha1_pkg::K0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = sha1_pkg::K1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = sha1_pkg::K2;
			end else begin
				f = b ^ c ^ d;
				k = sha1_pkg::K3;
			end
			t = {a[26:0], a[31:27]} + f + e + k + w[r];
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
	endfunction

	function automatic void buffer_byte(input logic [7:0] v);
		blk_buf[blk_fill] = v;
		blk_fill = blk_fill + 6'd1;
		if (blk_fill == 6'd0)
			compress_block();
	endfunction

	function automatic void restart_chain();
		for (int i = 0; i < sha1_pkg::NUM_WORDS; i++)
			chain_h[i] = sha1_pkg::H_INIT[i];
		msg_bytes = '0;
		blk_fill = '0;
	endfunction

	// Pad, append the bit length, queue the five digest words, start over
	function automatic void finish_digest();
		logic [63:0] bit_len;
		digest_word_t dw;
		bit_len = {msg_bytes, 3'b000};
		buffer_byte(sha1_pkg::PAD_BYTE);
		while (blk_fill != sha1_pkg::LEN_POS)
			buffer_byte(8'h00);
		for (int i = 0; i < 8; i++)
			buffer_byte(bit_len[63-8*i -: 8]);
		for (int i = 0; i < sha1_pkg::NUM_WORDS; i++) begin
			dw.word = chain_h[i];
			dw.idx = 3'(i);
			dw.last = (i == sha1_pkg::NUM_WORDS - 1);
			digest_q.push_back(dw);
		end
		restart_chain();
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	task automatic add_item(input logic func, input logic [7:0] data);
		msg_item_t it;
		it.func = func;
		it.data = data;
		item_q.push_back(it);
		planned_items++;
	endtask

	// Idle pattern follows the number of items taken so far
	always_comb begin
		unique case ((items_taken / 50) % 4)
			0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
			1: begin send_idle_pct = 46; recv_idle_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_idle_pct = 46; end
			default: begin send_idle_pct = 15; recv_idle_pct = 15; end
		endcase
	end

	// Offer items from the queue; predict on each accepted item
	always @(posedge clk) begin : drive
		msg_item_t nxt;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				items_taken <= items_taken + 1;
				if (s_axis_tuser == sha1_pkg::FUNC_FINISH) begin
					finish_digest();
				end else begin
					msg_bytes = msg_bytes + 61'd1;
					buffer_byte(s_axis_tdata);
				end
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = item_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= nxt.data;
					s_axis_tuser <= nxt.func;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Hold off the output once for a long stretch so the input backs up
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && items_taken >= HOLD_START) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end
		end
	end

	// Randomly stall the result side
	always @(posedge clk) begin
		if (arst_n)
			m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
	end

	// Compare each accepted result with the oldest expected digest word
	always @(posedge clk) begin : watch
		digest_word_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (digest_q.size() == 0) begin
				report_mismatch($sformatf("unexpected word %h idx %0d",
					m_axis_tdata, m_axis_tuser));
			end else begin
				want = digest_q.pop_front();
				if (m_axis_tdata !== want.word)
					report_mismatch($sformatf("word %0d: got %h want %h",
						want.idx, m_axis_tdata, want.word));
				if (m_axis_tuser !== want.idx)
					report_mismatch($sformatf("index: got %0d want %0d",
						m_axis_tuser, want.idx));
				if (m_axis_tlast !== want.last)
					report_mismatch($sformatf("word %0d: last got %b want %b",
						want.idx, m_axis_tlast, want.last));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb failed");
			$finish;
		end
	end

	initial begin : stim
		int len;
		int edge_lens [10];
		edge_lens = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120};
		restart_chain();
		for (int i = 0; i < sha1_pkg::BLOCK_BYTES; i++)
			blk_buf[i] = 8'h00;

		// Empty message
		add_item(sha1_pkg::FUNC_FINISH, 8'h00);
		// "abc"
		add_item(sha1_pkg::FUNC_ABSORB, 8'h61);
		add_item(sha1_pkg::FUNC_ABSORB, 8'h62);
		add_item(sha1_pkg::FUNC_ABSORB, 8'h63);
		add_item(sha1_pkg::FUNC_FINISH, 8'h00);
		// Extreme byte values, finish with a nonzero data byte that must be ignored
		add_item(sha1_pkg::FUNC_ABSORB, 8'h00);
		add_item(sha1_pkg::FUNC_ABSORB, 8'hFF);
		add_item(sha1_pkg::FUNC_ABSORB, 8'h80);
		add_item(sha1_pkg::FUNC_FINISH, 8'hFF);

		// Random messages, many at padding boundaries
		while (planned_items < TARGET_ITEMS) begin
			if ($urandom_range(2) == 0)
				len = edge_lens[$urandom_range(9)];
			else
				len = $urandom_range(40);
			repeat (len) add_item(sha1_pkg::FUNC_ABSORB, 8'($urandom_range(255)));
			add_item(sha1_pkg::FUNC_FINISH, 8'($urandom_range(255)));
		end

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (items_taken != planned_items) @(posedge clk);
		while (digest_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
